// ===== hdl/mxa_pkg.sv =====
package mxa_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 6;   // row, column and inner index of one multiply pass

  localparam logic [IDX_W-1:0] LAST_IDX = 4'd15;

  localparam logic [1:0] MODE_LOAD      = 2'd0;
  localparam logic [1:0] MODE_MUL       = 2'd1;
  localparam logic [1:0] MODE_TRANSPOSE = 2'd2;
  localparam logic [1:0] MODE_IDENTITY  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FILL,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } mxa_wr_t;

  typedef struct packed {
    logic             v;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] idx;
  } mxa_mac_ctl_t;

endpackage

// ===== hdl/mxa_ram.sv =====
module mxa_ram #(
  parameter int W  = 32,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/mxa_mac.sv =====
module mxa_mac import mxa_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mxa_mac_ctl_t       ctl,
  input  logic [DATA_W-1:0]  a_data,
  input  logic [DATA_W-1:0]  b_data,
  output mxa_wr_t            wr,
  output logic               busy
);

  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W - FRAC_BITS + 2;

  mxa_mac_ctl_t             ctl_d1_r;
  mxa_mac_ctl_t             ctl_d2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic signed [DATA_W-1:0] a_s;
  logic signed [DATA_W-1:0] b_s;
  logic signed [PROD_W-1:0] prod_shr;
  logic signed [ACC_W-1:0]  acc_base;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic                     in_range;
  logic [DATA_W-1:0]        sat_val;

  assign a_s = signed'(a_data);
  assign b_s = signed'(b_data);

  // memory read data is registered; control goes through ctl_d1_r, ctl_d2_r to match
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_d1_r <= '0;
      ctl_d2_r <= '0;
    end else begin
      ctl_d1_r <= ctl;
      ctl_d2_r <= ctl_d1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a_s * b_s;
    if (ctl_d2_r.v) begin
      acc_r <= acc_nxt;
    end
  end

  // floor shift of the full product, then accumulate at full width
  assign prod_shr = prod_r >>> FRAC_BITS;
  assign acc_base = ctl_d2_r.first ? '0 : acc_r;
  assign acc_nxt  = acc_base + ACC_W'(prod_shr);

  assign in_range = (&acc_nxt[ACC_W-1:DATA_W-1]) || !(|acc_nxt[ACC_W-1:DATA_W-1]);

  always_comb begin
    if (in_range) begin
      sat_val = acc_nxt[DATA_W-1:0];
    end else if (acc_nxt[ACC_W-1]) begin
      sat_val = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  assign wr.en   = ctl_d2_r.v && ctl_d2_r.last;
  assign wr.addr = ctl_d2_r.idx;
  assign wr.data = sat_val;
  assign busy    = ctl_d1_r.v || ctl_d2_r.v;

endmodule

// ===== hdl/mxa_seq.sv =====
module mxa_seq import mxa_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_mode,
  input  logic signed [DATA_W-1:0] in_element,
  input  logic [DATA_W-1:0]        cur_rdata,
  input  logic [DATA_W-1:0]        pbuf_rdata,
  input  mxa_wr_t                  mac_wr,
  input  logic                     mac_busy,
  output mxa_wr_t                  cur_wr,
  output mxa_wr_t                  op_wr,
  output mxa_wr_t                  pbuf_wr,
  output logic [IDX_W-1:0]         cur_raddr,
  output logic [IDX_W-1:0]         op_raddr,
  output logic [IDX_W-1:0]         pbuf_raddr,
  output mxa_mac_ctl_t             mac_ctl,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_value,
  output logic [IDX_W-1:0]         out_position,
  output logic                     out_final_res
);

  localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] elem_cnt_r, elem_cnt_nxt;
  logic [1:0]       grp_mode_r, grp_mode_nxt;
  logic             fill_v_r, fill_v_nxt;
  logic             emit_v_r, emit_v_nxt;
  logic             fill_id_r, fill_id_nxt;
  logic [IDX_W-1:0] fill_idx_r, fill_idx_nxt;
  logic [IDX_W-1:0] emit_idx_r, emit_idx_nxt;

  logic             accept;
  logic [IDX_W-1:0] ld_idx;
  logic [DATA_W-1:0] ident_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      elem_cnt_r <= '0;
      grp_mode_r <= MODE_LOAD;
      fill_v_r   <= 1'b0;
      emit_v_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      elem_cnt_r <= elem_cnt_nxt;
      grp_mode_r <= grp_mode_nxt;
      fill_v_r   <= fill_v_nxt;
      emit_v_r   <= emit_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_id_r  <= fill_id_nxt;
    fill_idx_r <= fill_idx_nxt;
    emit_idx_r <= emit_idx_nxt;
  end

  assign busy   = (state_r != ST_IDLE) || emit_v_r;
  assign accept = start && !busy;
  // a mode change inside a group restarts the element count
  assign ld_idx = (in_mode != grp_mode_r) ? '0 : elem_cnt_r;
  assign ident_val = (fill_idx_r[3:2] == fill_idx_r[1:0]) ? ONE : '0;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    elem_cnt_nxt = elem_cnt_r;
    grp_mode_nxt = grp_mode_r;
    fill_v_nxt   = 1'b0;
    emit_v_nxt   = 1'b0;
    fill_id_nxt  = fill_id_r;
    fill_idx_nxt = fill_idx_r;
    emit_idx_nxt = emit_idx_r;
    cur_wr       = '0;
    op_wr        = '0;
    cur_raddr    = '0;
    op_raddr     = '0;
    pbuf_raddr   = '0;
    mac_ctl      = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_LOAD: begin
              grp_mode_nxt = in_mode;
              cur_wr       = '{en: 1'b1, addr: ld_idx, data: in_element};
              elem_cnt_nxt = ld_idx + 4'd1;
            end
            MODE_MUL: begin
              grp_mode_nxt = in_mode;
              op_wr        = '{en: 1'b1, addr: ld_idx, data: in_element};
              if (ld_idx == LAST_IDX) begin
                elem_cnt_nxt = '0;
                state_nxt    = ST_MUL;
                cnt_nxt      = '0;
              end else begin
                elem_cnt_nxt = ld_idx + 4'd1;
              end
            end
            MODE_TRANSPOSE, MODE_IDENTITY: begin
              grp_mode_nxt = in_mode;
              elem_cnt_nxt = '0;
              state_nxt    = ST_FILL;
              cnt_nxt      = '0;
              fill_id_nxt  = (in_mode == MODE_IDENTITY);
            end
            default: begin
            end
          endcase
        end
      end
      ST_MUL: begin
        // cnt = {row, col, k}
        cur_raddr     = {cnt_r[5:4], cnt_r[1:0]};
        op_raddr      = {cnt_r[1:0], cnt_r[3:2]};
        mac_ctl.v     = 1'b1;
        mac_ctl.first = (cnt_r[1:0] == 2'd0);
        mac_ctl.last  = &cnt_r[1:0];
        mac_ctl.idx   = cnt_r[5:2];
        cnt_nxt       = cnt_r + 6'd1;
        if (&cnt_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_FILL: begin
        cur_raddr    = {cnt_r[1:0], cnt_r[3:2]};
        fill_v_nxt   = 1'b1;
        fill_idx_nxt = cnt_r[IDX_W-1:0];
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r[IDX_W-1:0] == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy && !fill_v_r) begin
          state_nxt = ST_EMIT;
          cnt_nxt   = '0;
        end
      end
      ST_EMIT: begin
        pbuf_raddr   = cnt_r[IDX_W-1:0];
        emit_v_nxt   = 1'b1;
        emit_idx_nxt = cnt_r[IDX_W-1:0];
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r[IDX_W-1:0] == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // copy-back into the current matrix runs alongside emission
    if (emit_v_r) begin
      cur_wr = '{en: 1'b1, addr: emit_idx_r, data: pbuf_rdata};
    end
  end

  always_comb begin
    if (fill_v_r) begin
      pbuf_wr = '{en: 1'b1, addr: fill_idx_r, data: (fill_id_r ? ident_val : cur_rdata)};
    end else begin
      pbuf_wr = mac_wr;
    end
  end

  assign out_valid     = emit_v_r;
  assign out_value     = signed'(pbuf_rdata);
  assign out_position  = emit_idx_r;
  assign out_final_res = emit_v_r && (emit_idx_r == LAST_IDX);

endmodule

// ===== hdl/matrix4_transform_accumulator_unit.sv =====
// 4x4 signed fixed-point matrix accumulator (FRAC_BITS fractional bits). A transaction is
// taken when start is high and busy is low. Load (mode 0) and non-final operand elements
// (mode 1) each write one element and produce nothing. The sixteenth operand element starts
// current = current x operand: 64 multiply-accumulates on a single 32x32 multiplier, one per
// cycle, reading the current and operand memories, then the 16 results are copied back from
// the product buffer and emitted in order of position. Transpose and identity rebuild the
// matrix through the product buffer and emit likewise. Results are marked by out_valid for
// one cycle each and cannot be stalled; out_final_res flags the sixteenth. There is no
// clearing pass after reset.
module matrix4_transform_accumulator_unit import mxa_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_mode,
  input  logic signed [DATA_W-1:0] in_element,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_value,
  output logic [IDX_W-1:0]         out_position,
  output logic                     out_final_res
);

  localparam int               DEPTH = 2**IDX_W;
  localparam logic [DATA_W-1:0] ONE  = DATA_W'(1) << FRAC_BITS;

  mxa_wr_t          cur_wr, op_wr, pbuf_wr, mac_wr;
  mxa_mac_ctl_t     mac_ctl;
  logic             mac_busy;
  logic [IDX_W-1:0] cur_raddr, op_raddr, pbuf_raddr;
  logic [DATA_W-1:0] cur_raw, cur_rdata, op_rdata, pbuf_rdata;

  logic [DEPTH-1:0] cur_vld_r;
  logic [IDX_W-1:0] cur_raddr_r;

  // entries never written since reset read as the identity matrix
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= '0;
    end else if (cur_wr.en) begin
      cur_vld_r[cur_wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cur_raddr_r <= cur_raddr;
  end

  always_comb begin
    if (cur_vld_r[cur_raddr_r]) begin
      cur_rdata = cur_raw;
    end else if (cur_raddr_r[3:2] == cur_raddr_r[1:0]) begin
      cur_rdata = ONE;
    end else begin
      cur_rdata = '0;
    end
  end

  mxa_ram #(.W(DATA_W), .AW(IDX_W)) u_cur_ram (
    .clk   (clk),
    .we    (cur_wr.en),
    .waddr (cur_wr.addr),
    .wdata (cur_wr.data),
    .raddr (cur_raddr),
    .rdata (cur_raw)
  );

  mxa_ram #(.W(DATA_W), .AW(IDX_W)) u_op_ram (
    .clk   (clk),
    .we    (op_wr.en),
    .waddr (op_wr.addr),
    .wdata (op_wr.data),
    .raddr (op_raddr),
    .rdata (op_rdata)
  );

  mxa_ram #(.W(DATA_W), .AW(IDX_W)) u_pbuf_ram (
    .clk   (clk),
    .we    (pbuf_wr.en),
    .waddr (pbuf_wr.addr),
    .wdata (pbuf_wr.data),
    .raddr (pbuf_raddr),
    .rdata (pbuf_rdata)
  );

  mxa_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .a_data (cur_rdata),
    .b_data (op_rdata),
    .wr     (mac_wr),
    .busy   (mac_busy)
  );

  mxa_seq #(.FRAC_BITS(FRAC_BITS)) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_element    (in_element),
    .cur_rdata     (cur_rdata),
    .pbuf_rdata    (pbuf_rdata),
    .mac_wr        (mac_wr),
    .mac_busy      (mac_busy),
    .cur_wr        (cur_wr),
    .op_wr         (op_wr),
    .pbuf_wr       (pbuf_wr),
    .cur_raddr     (cur_raddr),
    .op_raddr      (op_raddr),
    .pbuf_raddr    (pbuf_raddr),
    .mac_ctl       (mac_ctl),
    .out_valid     (out_valid),
    .out_value     (out_value),
    .out_position  (out_position),
    .out_final_res (out_final_res)
  );

endmodule
